// ===== sv/ypb_pkg.sv =====
// shared types, cordic constants and arctangent table for the yaw/pitch basis block
package ypb_pkg;

    // number of cordic rotation steps, one cell each
    localparam int CORDIC_STEPS = 30;

    // width of the cordic x, y and z datapath (q30 values with headroom)
    localparam int CW = 34;

    // 1/K in q30, start value of x
    localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;

    // one in q30
    localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;

    // arctangent of 2^-i as a 32-bit binary angle
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // one cordic rotator state
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_rot;

    // what travels down the cell chain: both angles in flight
    typedef struct packed {
        logic       vld;
        logic [1:0] q_yaw;
        logic [1:0] q_pitch;
        t_rot       yaw;
        t_rot       pitch;
    } t_lane;

    // basis vectors in q30, right_y is always zero and not carried
    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic signed [31:0] rx;
        logic signed [31:0] rz;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
    } t_basis;

endpackage

// ===== sv/ypb_cordic_cell.sv =====
// one rotation-mode cordic cell, handling the yaw and the pitch rotator
module ypb_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ypb_pkg::t_lane  i_lane,
    output ypb_pkg::t_lane  o_lane
);

    localparam int CW = ypb_pkg::CW;

    // arctangent of this step, zero extended
    localparam logic signed [CW-1:0] ATAN_STEP =
        {{(CW-32){1'b0}}, ypb_pkg::ATAN_TURN[STEP]};

    logic           r_vld;
    ypb_pkg::t_lane r_lane;
    ypb_pkg::t_lane n_lane;

    // single micro-rotation, floor shifts
    function automatic ypb_pkg::t_rot rotate(input ypb_pkg::t_rot v);
        ypb_pkg::t_rot        o;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = v.y >>> STEP;
        dy = v.x >>> STEP;
        if (!v.z[CW-1]) begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - ATAN_STEP;
        end else begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + ATAN_STEP;
        end
        return o;
    endfunction

    // next state of both rotators
    always_comb begin
        n_lane       = i_lane;
        n_lane.yaw   = rotate(i_lane.yaw);
        n_lane.pitch = rotate(i_lane.pitch);
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_lane.vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    always_comb begin
        o_lane     = r_lane;
        o_lane.vld = r_vld;
    end

endmodule

// ===== sv/ypb_basis.sv =====
// quadrant fold, products and cross product for the three basis vectors
module ypb_basis (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ypb_pkg::t_lane  i_lane,
    output logic            o_vld,
    output ypb_pkg::t_basis o_basis
);

    localparam int CW = ypb_pkg::CW;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

    // stage valid flags
    logic [4:0] r_vld;

    // stage a: sine and cosine
    logic signed [31:0] r_a_cy, r_a_sy, r_a_cp, r_a_sp;
    logic signed [31:0] n_a_cy, n_a_sy, n_a_cp, n_a_sp;
    // stage b: forward products
    logic signed [63:0] r_b_mfx, r_b_mfz;
    logic signed [31:0] r_b_cy, r_b_sy, r_b_sp;
    // stage c: forward and right vectors
    logic signed [31:0] r_c_fx, r_c_fy, r_c_fz, r_c_rx, r_c_rz;
    // stage d: cross product terms
    logic signed [63:0] r_d_mux, r_d_muy1, r_d_muy2, r_d_muz;
    logic signed [31:0] r_d_fx, r_d_fy, r_d_fz, r_d_rx, r_d_rz;
    // stage e: full basis
    ypb_pkg::t_basis    r_e_basis;

    // saturate a cordic value to plus or minus one
    function automatic logic signed [31:0] sat_q30(input logic signed [CW-1:0] v);
        if (v > ypb_pkg::ONE_Q30) begin
            return 32'sd1073741824;
        end else if (v < -ypb_pkg::ONE_Q30) begin
            return -32'sd1073741824;
        end else begin
            return v[31:0];
        end
    endfunction

    // product back to q30, rounded and saturated
    function automatic logic signed [31:0] norm_q30(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [33:0] s;
        t = (p + HALF_Q30) >>> 30;
        s = t[33:0];
        if (t > 64'sd1073741824) begin
            return 32'sd1073741824;
        end else if (t < -64'sd1073741824) begin
            return -32'sd1073741824;
        end else begin
            return s[31:0];
        end
    endfunction

    // map rotator results to cos and sin by quadrant
    always_comb begin
        logic signed [CW-1:0] cy, sy, cp, sp;
        case (i_lane.q_yaw)
            QUAD_0: begin cy = i_lane.yaw.x;  sy = i_lane.yaw.y;  end
            QUAD_1: begin cy = -i_lane.yaw.y; sy = i_lane.yaw.x;  end
            QUAD_2: begin cy = -i_lane.yaw.x; sy = -i_lane.yaw.y; end
            default: begin cy = i_lane.yaw.y; sy = -i_lane.yaw.x; end
        endcase
        case (i_lane.q_pitch)
            QUAD_0: begin cp = i_lane.pitch.x;  sp = i_lane.pitch.y;  end
            QUAD_1: begin cp = -i_lane.pitch.y; sp = i_lane.pitch.x;  end
            QUAD_2: begin cp = -i_lane.pitch.x; sp = -i_lane.pitch.y; end
            default: begin cp = i_lane.pitch.y; sp = -i_lane.pitch.x; end
        endcase
        n_a_cy = sat_q30(cy);
        n_a_sy = sat_q30(sy);
        n_a_cp = sat_q30(cp);
        n_a_sp = sat_q30(sp);
    end

    // valid flags down the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_lane.vld};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cy <= n_a_cy;
            r_a_sy <= n_a_sy;
            r_a_cp <= n_a_cp;
            r_a_sp <= n_a_sp;

            r_b_mfx <= r_a_cp * r_a_sy;
            r_b_mfz <= r_a_cp * r_a_cy;
            r_b_cy  <= r_a_cy;
            r_b_sy  <= r_a_sy;
            r_b_sp  <= r_a_sp;

            r_c_fx <= norm_q30(r_b_mfx);
            r_c_fy <= r_b_sp;
            r_c_fz <= norm_q30(r_b_mfz);
            r_c_rx <= -r_b_cy;
            r_c_rz <= r_b_sy;

            r_d_mux  <= r_c_rz * r_c_fy;
            r_d_muy1 <= r_c_rz * r_c_fx;
            r_d_muy2 <= r_c_rx * r_c_fz;
            r_d_muz  <= r_c_rx * r_c_fy;
            r_d_fx   <= r_c_fx;
            r_d_fy   <= r_c_fy;
            r_d_fz   <= r_c_fz;
            r_d_rx   <= r_c_rx;
            r_d_rz   <= r_c_rz;

            r_e_basis.fx <= r_d_fx;
            r_e_basis.fy <= r_d_fy;
            r_e_basis.fz <= r_d_fz;
            r_e_basis.rx <= r_d_rx;
            r_e_basis.rz <= r_d_rz;
            r_e_basis.ux <= norm_q30(-r_d_mux);
            r_e_basis.uy <= norm_q30(r_d_muy1 - r_d_muy2);
            r_e_basis.uz <= norm_q30(r_d_muz);
        end
    end

    assign o_vld   = r_vld[4];
    assign o_basis = r_e_basis;

    // yaw cosine and pitch sine are always within plus or minus one after the fold
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_a_cy <= 32'sd1073741824 && r_a_cy >= -32'sd1073741824 &&
                      r_a_sp <= 32'sd1073741824 && r_a_sp >= -32'sd1073741824))
        else $error("sine or cosine out of range");

    // stage flags only move on an enabled cycle
    a_vld_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld))
        else $error("basis stage flags moved while held");

endmodule

// ===== sv/yaw_pitch_to_basis_vectors.sv =====
// top level: camera basis vectors from yaw and pitch binary angles
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+---------------------------------------------
//  request  | i_valid  | o_stall  | i_yaw_angle, i_pitch_angle
//  result   | o_valid  | i_stall  | o_forward_*, o_right_*, o_upward_*
//
// one request per cycle while o_stall is low; the path runs through 30 cordic cells,
// five product stages and the output register.
// synchronous active-low reset clears every valid flag; payload registers are not reset.
// a stalled result sits in the output register while one more finished result parks in
// the skid register; only a full skid register holds the pipeline and raises o_stall.
module yaw_pitch_to_basis_vectors #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_yaw_angle,
    input  logic [15:0]        i_pitch_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_forward_x,
    output logic signed [15:0] o_forward_y,
    output logic signed [15:0] o_forward_z,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic signed [15:0] o_right_z,
    output logic signed [15:0] o_upward_x,
    output logic signed [15:0] o_upward_y,
    output logic signed [15:0] o_upward_z
);

    localparam int CW    = ypb_pkg::CW;
    localparam int STEPS = ypb_pkg::CORDIC_STEPS;

    localparam logic [31:0] ANGLE_MASK = (32'd1 << ANGLE_BITS) - 32'd1;
    localparam int          FIELD_SH   = 30 - FRAC_BITS;
    localparam logic signed [32:0] FIELD_HALF =
        (FIELD_SH == 0) ? 33'sd0 : (33'sd1 <<< (FIELD_SH - 1));
    localparam logic signed [32:0] FIELD_LIM = 33'sd1 <<< FRAC_BITS;

    // one result in output format
    typedef struct packed {
        logic signed [15:0] fx, fy, fz;
        logic signed [15:0] rx, ry, rz;
        logic signed [15:0] ux, uy, uz;
    } t_fields;

    logic            en;
    logic            take;
    ypb_pkg::t_lane  w_lane [0:STEPS];
    logic            b_vld;
    ypb_pkg::t_basis b_basis;
    t_fields         f_new;
    logic            r_out_vld;
    logic            r_skid_vld;
    t_fields         r_out;
    t_fields         r_skid;

    // binary angle to quadrant and signed residual
    function automatic void prep_angle(input logic [15:0] ang, output logic [1:0] q,
                                       output logic signed [CW-1:0] z);
        logic [31:0] a;
        logic [31:0] s;
        logic [31:0] r;
        a = (32'(ang) & ANGLE_MASK) << (32 - ANGLE_BITS);
        s = a + 32'h2000_0000;
        q = s[31:30];
        r = a - {q, 30'd0};
        z = {{(CW-32){r[31]}}, r};
    endfunction

    // q30 to output field, rounded and saturated
    function automatic logic signed [15:0] to_field(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = (33'(v) + FIELD_HALF) >>> FIELD_SH;
        if (t > FIELD_LIM) begin
            t = FIELD_LIM;
        end else if (t < -FIELD_LIM) begin
            t = -FIELD_LIM;
        end
        return t[15:0];
    endfunction

    // handshake: pipeline moves unless the skid register is full
    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;
    assign take    = r_out_vld && !i_stall;

    // head of the cell chain
    always_comb begin
        w_lane[0].vld     = i_valid;
        w_lane[0].yaw.x   = ypb_pkg::GAIN_INV;
        w_lane[0].yaw.y   = '0;
        w_lane[0].pitch.x = ypb_pkg::GAIN_INV;
        w_lane[0].pitch.y = '0;
        prep_angle(i_yaw_angle, w_lane[0].q_yaw, w_lane[0].yaw.z);
        prep_angle(i_pitch_angle, w_lane[0].q_pitch, w_lane[0].pitch.z);
    end

    // row of cordic cells
    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        ypb_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_lane  (w_lane[k]),
            .o_lane  (w_lane[k+1])
        );
    end

    // products and cross product
    ypb_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_lane  (w_lane[STEPS]),
        .o_vld   (b_vld),
        .o_basis (b_basis)
    );

    // output formatting
    always_comb begin
        f_new.fx = to_field(b_basis.fx);
        f_new.fy = to_field(b_basis.fy);
        f_new.fz = to_field(b_basis.fz);
        f_new.rx = to_field(b_basis.rx);
        f_new.ry = '0;
        f_new.rz = to_field(b_basis.rz);
        f_new.ux = to_field(b_basis.ux);
        f_new.uy = to_field(b_basis.uy);
        f_new.uz = to_field(b_basis.uz);
    end

    // output and skid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (b_vld) begin
            if (r_out_vld && !take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (b_vld) begin
            if (r_out_vld && !take) begin
                r_skid <= f_new;
            end else begin
                r_out <= f_new;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_forward_x = r_out.fx;
    assign o_forward_y = r_out.fy;
    assign o_forward_z = r_out.fz;
    assign o_right_x   = r_out.rx;
    assign o_right_y   = r_out.ry;
    assign o_right_z   = r_out.rz;
    assign o_upward_x  = r_out.ux;
    assign o_upward_y  = r_out.uy;
    assign o_upward_z  = r_out.uz;

    // a parked result always has one ahead of it
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full with empty output register");

    // a finished result meeting a stalled full output goes to the skid register
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_vld && r_out_vld && i_stall && !r_skid_vld) |=> r_skid_vld)
        else $error("finished result not parked");

    // a drained skid register moves into the output register
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_stall) |=> (r_out_vld && !r_skid_vld))
        else $error("skid register did not drain");

    // the right vector has no vertical part
    a_right_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_right_y == 16'sd0))
        else $error("right_y not zero");

endmodule
